// ===== hw/rtl/detection_box_decode_top_assert.svh =====
// Assertion macros for the detection box decoder checker.
// Used by dbd_checker.sv; depends on nothing else.
`ifndef DETECTION_BOX_DECODE_TOP_ASSERT_SVH
`define DETECTION_BOX_DECODE_TOP_ASSERT_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define DBD_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// The condition must never be seen outside reset.
`define DBD_ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(cond)) \
        else $error(msg);

`endif

// ===== hw/rtl/dbd_pkg.sv =====
// Shared types and constants for the detection box decoder.
// No dependencies; imported by the RTL and the benches.
package dbd_pkg;

    // Port widths fixed by the row and result formats.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int COORD_W    = 16;
    localparam int SCORE_W    = 16;
    localparam int CORNER_W   = 12;

    // Largest corner value that fits the result fields.
    localparam logic [CORNER_W-1:0] CORNER_MAX = 12'd4095;

    // Register reset values.
    localparam logic [15:0] RST_CONF_THRESHOLD = 16'd16384;
    localparam logic [12:0] RST_LETTERBOX_SIZE = 13'd320;
    localparam logic [11:0] RST_PAD_LEFT       = 12'd0;
    localparam logic [11:0] RST_PAD_TOP        = 12'd0;
    localparam logic [23:0] RST_INV_SCALE      = 24'd65536;
    localparam logic [12:0] RST_ORIG_WIDTH     = 13'd640;
    localparam logic [12:0] RST_ORIG_HEIGHT    = 13'd480;
    localparam logic [1:0]  RST_SCORE_FORMAT   = 2'd0;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CONF_THRESHOLD = 3'd0,
        REG_LETTERBOX_SIZE = 3'd1,
        REG_PAD_LEFT       = 3'd2,
        REG_PAD_TOP        = 3'd3,
        REG_INV_SCALE      = 3'd4,
        REG_ORIG_WIDTH     = 3'd5,
        REG_ORIG_HEIGHT    = 3'd6,
        REG_SCORE_FORMAT   = 3'd7
    } cfg_idx_t;

    // Score formats; the remaining codes drop every row.
    typedef enum logic [1:0] {
        FMT_DIRECT    = 2'd0,
        FMT_OBJ_CLASS = 2'd1
    } score_fmt_t;

endpackage

// ===== hw/rtl/detection_box_decode_top.sv =====
// A row accepted at a clock edge passes the input, score and box, intersect and scale
// multiplier registers and shows its result with done high from the output register.
// Throughput: one row per cycle; busy stays low, the five-register pipeline
// (input, score and box, intersect, scale multipliers, output) never stalls.
// Reset clears the pipeline valid bits and loads every configuration register's default.
// The receiver cannot stall: each result is shown for exactly one cycle.
module detection_box_decode_top #(
    parameter int COORD_FRAC_BITS = 4,
    parameter int SCALE_FRAC_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dbd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dbd_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Row requests
    input  logic                             start,
    output logic                             busy,
    input  logic [dbd_pkg::COORD_W-1:0]      center_x,
    input  logic [dbd_pkg::COORD_W-1:0]      center_y,
    input  logic [dbd_pkg::COORD_W-1:0]      box_width,
    input  logic [dbd_pkg::COORD_W-1:0]      box_height,
    input  logic [dbd_pkg::SCORE_W-1:0]      score_a,
    input  logic [dbd_pkg::SCORE_W-1:0]      score_b,
    // Results
    output logic                             done,
    output logic                             keep,
    output logic [dbd_pkg::CORNER_W-1:0]     left,
    output logic [dbd_pkg::CORNER_W-1:0]     top,
    output logic [dbd_pkg::CORNER_W-1:0]     right,
    output logic [dbd_pkg::CORNER_W-1:0]     bottom,
    output logic [dbd_pkg::SCORE_W-1:0]      score
);
    import dbd_pkg::*;

    // Integer box corner width, box size width, compute width, product width, rounded width.
    localparam int XW = 19 - COORD_FRAC_BITS;
    localparam int WW = 17 - COORD_FRAC_BITS;
    localparam int CW = (XW + 2 > 15) ? XW + 2 : 15;
    localparam int PW = CW + 25;
    localparam int RW = PW + 1 - SCALE_FRAC_BITS;

    // Rounding offsets for the corner, the size and the scaled value.
    localparam logic [18:0] X_HALF = 19'(1 << COORD_FRAC_BITS);
    localparam logic [16:0] W_HALF = 17'((1 << COORD_FRAC_BITS) >> 1);
    localparam logic [PW:0] P_HALF = (PW + 1)'(1) << (SCALE_FRAC_BITS - 1);

    // Round a corner value by COORD_FRAC_BITS + 1, ties away from zero.
    function automatic logic signed [18:0] round_coord(input logic signed [18:0] v);
        logic [18:0] mag;
        logic [18:0] q;
        mag = v[18] ? 19'(-v) : 19'(v);
        q   = (mag + X_HALF) >> (COORD_FRAC_BITS + 1);
        return v[18] ? -$signed(q) : $signed(q);
    endfunction

    // Clamp limit of one image axis, saturated to the corner range.
    function automatic logic [CORNER_W-1:0] clamp_limit(input logic [12:0] size);
        if (size == 13'd0) begin
            return '0;
        end
        if (size > 13'd4096) begin
            return CORNER_MAX;
        end
        return CORNER_W'(size - 13'd1);
    endfunction

    // Round a scaled product to an integer and clamp it to [0, lim].
    function automatic logic [CORNER_W-1:0] scale_corner(
        input logic signed [PW-1:0] p,
        input logic [CORNER_W-1:0]  lim
    );
        logic [PW:0]   sum;
        logic [RW-1:0] q;
        if (p[PW-1]) begin
            return '0;
        end
        sum = {1'b0, p} + P_HALF;
        q   = RW'(sum >> SCALE_FRAC_BITS);
        if (q > RW'(lim)) begin
            return lim;
        end
        return q[CORNER_W-1:0];
    endfunction

    // Configuration registers.
    logic [15:0] conf_threshold_reg;
    logic [12:0] letterbox_size_reg;
    logic [11:0] pad_left_reg;
    logic [11:0] pad_top_reg;
    logic [23:0] inv_scale_reg;
    logic [12:0] orig_width_reg;
    logic [12:0] orig_height_reg;
    logic [1:0]  score_format_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    // Register writes; user changes configuration only with no row in flight; unchecked.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conf_threshold_reg <= RST_CONF_THRESHOLD;
            letterbox_size_reg <= RST_LETTERBOX_SIZE;
            pad_left_reg       <= RST_PAD_LEFT;
            pad_top_reg        <= RST_PAD_TOP;
            inv_scale_reg      <= RST_INV_SCALE;
            orig_width_reg     <= RST_ORIG_WIDTH;
            orig_height_reg    <= RST_ORIG_HEIGHT;
            score_format_reg   <= RST_SCORE_FORMAT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_CONF_THRESHOLD: conf_threshold_reg <= cfg_data[15:0];
                REG_LETTERBOX_SIZE: letterbox_size_reg <= cfg_data[12:0];
                REG_PAD_LEFT:       pad_left_reg       <= cfg_data[11:0];
                REG_PAD_TOP:        pad_top_reg        <= cfg_data[11:0];
                REG_INV_SCALE:      inv_scale_reg      <= cfg_data[23:0];
                REG_ORIG_WIDTH:     orig_width_reg     <= cfg_data[12:0];
                REG_ORIG_HEIGHT:    orig_height_reg    <= cfg_data[12:0];
                REG_SCORE_FORMAT:   score_format_reg   <= cfg_data[1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register.
    // ------------------------------------------------------------------
    logic               in_valid_reg;
    logic [COORD_W-1:0] cx_reg, cy_reg, bw_reg, bh_reg;
    logic [SCORE_W-1:0] sa_reg, sb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cx_reg <= center_x;
            cy_reg <= center_y;
            bw_reg <= box_width;
            bh_reg <= box_height;
            sa_reg <= score_a;
            sb_reg <= score_b;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: score selection and integer box in letterbox pixels.
    // ------------------------------------------------------------------
    logic [31:0]          s1_prod;
    logic signed [18:0]   s1_vx, s1_vy;
    logic                 s1_drop_next;
    logic [SCORE_W-1:0]   s1_score_next;
    logic signed [XW-1:0] s1_x_next, s1_y_next;
    logic [WW-1:0]        s1_w_next, s1_h_next;

    always_comb
    begin
        s1_prod = 32'(sa_reg) * 32'(sb_reg);
        unique case (score_format_reg)
            FMT_DIRECT:
            begin
                s1_drop_next  = 1'b0;
                s1_score_next = sa_reg;
            end
            FMT_OBJ_CLASS:
            begin
                s1_drop_next  = 1'b0;
                s1_score_next = s1_prod[31:16];
            end
            default:
            begin
                s1_drop_next  = 1'b1;
                s1_score_next = '0;
            end
        endcase
        // Left edge is (2 * center - size) / 2, rounded in one step.
        s1_vx     = $signed({2'b00, cx_reg, 1'b0}) - $signed({3'b000, bw_reg});
        s1_vy     = $signed({2'b00, cy_reg, 1'b0}) - $signed({3'b000, bh_reg});
        s1_x_next = XW'(round_coord(s1_vx));
        s1_y_next = XW'(round_coord(s1_vy));
        s1_w_next = WW'(({1'b0, bw_reg} + W_HALF) >> COORD_FRAC_BITS);
        s1_h_next = WW'(({1'b0, bh_reg} + W_HALF) >> COORD_FRAC_BITS);
    end

    logic                 s1_valid_reg;
    logic                 s1_drop_reg;
    logic [SCORE_W-1:0]   s1_score_reg;
    logic signed [XW-1:0] s1_x_reg, s1_y_reg;
    logic [WW-1:0]        s1_w_reg, s1_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_drop_reg  <= s1_drop_next;
        s1_score_reg <= s1_score_next;
        s1_x_reg     <= s1_x_next;
        s1_y_reg     <= s1_y_next;
        s1_w_reg     <= s1_w_next;
        s1_h_reg     <= s1_h_next;
    end

    // ------------------------------------------------------------------
    // Stage 2: threshold, intersection with the letterbox, padding removal.
    // ------------------------------------------------------------------
    logic signed [CW-1:0] lb_ext, padl_ext, padt_ext;
    logic signed [CW-1:0] x_lo, x_sz, x_hi, x1, x2;
    logic signed [CW-1:0] y_lo, y_sz, y_hi, y1, y2;
    logic                 s2_kept_next;
    logic signed [CW-1:0] s2_dl_next, s2_dr_next, s2_dt_next, s2_db_next;

    always_comb
    begin
        lb_ext   = $signed(CW'(letterbox_size_reg));
        padl_ext = $signed(CW'(pad_left_reg));
        padt_ext = $signed(CW'(pad_top_reg));
        x_lo     = CW'(s1_x_reg);
        x_sz     = $signed(CW'(s1_w_reg));
        x_hi     = x_lo + x_sz;
        y_lo     = CW'(s1_y_reg);
        y_sz     = $signed(CW'(s1_h_reg));
        y_hi     = y_lo + y_sz;
        // Clip both axes to [0, letterbox_size).
        x1       = x_lo[CW-1] ? '0 : x_lo;
        x2       = (x_hi < lb_ext) ? x_hi : lb_ext;
        y1       = y_lo[CW-1] ? '0 : y_lo;
        y2       = (y_hi < lb_ext) ? y_hi : lb_ext;
        s2_kept_next = !s1_drop_reg && (s1_score_reg >= conf_threshold_reg)
                       && (x2 > x1) && (y2 > y1);
        s2_dl_next = x1 - padl_ext;
        s2_dr_next = x2 - padl_ext;
        s2_dt_next = y1 - padt_ext;
        s2_db_next = y2 - padt_ext;
    end

    logic                 s2_valid_reg;
    logic                 s2_kept_reg;
    logic [SCORE_W-1:0]   s2_score_reg;
    logic signed [CW-1:0] s2_dl_reg, s2_dr_reg, s2_dt_reg, s2_db_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_kept_reg  <= s2_kept_next;
        s2_score_reg <= s1_score_reg;
        s2_dl_reg    <= s2_dl_next;
        s2_dr_reg    <= s2_dr_next;
        s2_dt_reg    <= s2_dt_next;
        s2_db_reg    <= s2_db_next;
    end

    // ------------------------------------------------------------------
    // Stage 3: four scale multipliers, one per corner coordinate.
    // ------------------------------------------------------------------
    logic signed [24:0]   scale_ext;
    logic signed [PW-1:0] s3_pl_next, s3_pr_next, s3_pt_next, s3_pb_next;

    always_comb
    begin
        scale_ext  = $signed({1'b0, inv_scale_reg});
        s3_pl_next = PW'(s2_dl_reg) * PW'(scale_ext);
        s3_pr_next = PW'(s2_dr_reg) * PW'(scale_ext);
        s3_pt_next = PW'(s2_dt_reg) * PW'(scale_ext);
        s3_pb_next = PW'(s2_db_reg) * PW'(scale_ext);
    end

    logic                 s3_valid_reg;
    logic                 s3_kept_reg;
    logic [SCORE_W-1:0]   s3_score_reg;
    logic signed [PW-1:0] s3_pl_reg, s3_pr_reg, s3_pt_reg, s3_pb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_kept_reg  <= s2_kept_reg;
        s3_score_reg <= s2_score_reg;
        s3_pl_reg    <= s3_pl_next;
        s3_pr_reg    <= s3_pr_next;
        s3_pt_reg    <= s3_pt_next;
        s3_pb_reg    <= s3_pb_next;
    end

    // ------------------------------------------------------------------
    // Stage 4: round, clamp to the original image, drop empty boxes.
    // ------------------------------------------------------------------
    logic [CORNER_W-1:0] x_lim, y_lim;
    logic [CORNER_W-1:0] l_val, r_val, t_val, b_val;
    logic                keep_next;
    logic [CORNER_W-1:0] left_next, top_next, right_next, bottom_next;
    logic [SCORE_W-1:0]  score_next;

    always_comb
    begin
        x_lim       = clamp_limit(orig_width_reg);
        y_lim       = clamp_limit(orig_height_reg);
        l_val       = scale_corner(s3_pl_reg, x_lim);
        r_val       = scale_corner(s3_pr_reg, x_lim);
        t_val       = scale_corner(s3_pt_reg, y_lim);
        b_val       = scale_corner(s3_pb_reg, y_lim);
        keep_next   = s3_kept_reg && (r_val != l_val) && (b_val != t_val);
        // A dropped row reports all-zero fields.
        left_next   = keep_next ? l_val : '0;
        right_next  = keep_next ? r_val : '0;
        top_next    = keep_next ? t_val : '0;
        bottom_next = keep_next ? b_val : '0;
        score_next  = keep_next ? s3_score_reg : '0;
    end

    logic                done_reg;
    logic                keep_reg;
    logic [CORNER_W-1:0] left_reg, top_reg, right_reg, bottom_reg;
    logic [SCORE_W-1:0]  score_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        keep_reg   <= keep_next;
        left_reg   <= left_next;
        top_reg    <= top_next;
        right_reg  <= right_next;
        bottom_reg <= bottom_next;
        score_reg  <= score_next;
    end

    assign done   = done_reg;
    assign keep   = keep_reg;
    assign left   = left_reg;
    assign top    = top_reg;
    assign right  = right_reg;
    assign bottom = bottom_reg;
    assign score  = score_reg;

endmodule

// ===== hw/rtl/dbd_checker.sv =====
// Port-level checker for detection_box_decode_top, attached by bind.
// Depends on dbd_pkg and the macros in detection_box_decode_top_assert.svh.
`include "detection_box_decode_top_assert.svh"

module dbd_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic                         keep,
    input logic [dbd_pkg::CORNER_W-1:0] left,
    input logic [dbd_pkg::CORNER_W-1:0] top,
    input logic [dbd_pkg::CORNER_W-1:0] right,
    input logic [dbd_pkg::CORNER_W-1:0] bottom,
    input logic [dbd_pkg::SCORE_W-1:0]  score
);
    import dbd_pkg::*;

    // Conditions that the assertions below look at.
    logic req_taken;
    logic fields_zero;
    logic box_ordered;

    assign req_taken   = start && !busy;
    assign fields_zero = (left == '0) && (top == '0) && (right == '0)
                         && (bottom == '0) && (score == '0);
    assign box_ordered = (right > left) && (bottom > top);

    // The decoder takes a row in every cycle.
    `DBD_ASSERT_NEVER(a_never_busy, clk, rst_n, busy, "busy raised")

    // Every result follows an accepted request.
    `DBD_ASSERT_IMPLY(a_done_latency, clk, rst_n, done, $past(req_taken, 5), "result without request")

    // A dropped row carries all-zero fields.
    `DBD_ASSERT_IMPLY(a_drop_zero, clk, rst_n, done && !keep, fields_zero, "dropped row not zero")

    // A kept box has positive width and height.
    `DBD_ASSERT_IMPLY(a_box_order, clk, rst_n, done && keep, box_ordered, "kept box is empty")

endmodule

bind detection_box_decode_top dbd_checker u_dbd_checker (.*);

// ===== verif/detection_box_decode_checker.sv =====
// Checker for the detection box decoder: follows register writes, predicts each row's result
// and compares it with the block's output in arrival order.
// Depends on dbd_pkg for the port widths, register indexes and score format codes.
module detection_box_decode_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [dbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dbd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           start,
    input  logic                           busy,
    input  logic [dbd_pkg::COORD_W-1:0]    center_x,
    input  logic [dbd_pkg::COORD_W-1:0]    center_y,
    input  logic [dbd_pkg::COORD_W-1:0]    box_width,
    input  logic [dbd_pkg::COORD_W-1:0]    box_height,
    input  logic [dbd_pkg::SCORE_W-1:0]    score_a,
    input  logic [dbd_pkg::SCORE_W-1:0]    score_b,
    input  logic                           done,
    input  logic                           keep,
    input  logic [dbd_pkg::CORNER_W-1:0]   left,
    input  logic [dbd_pkg::CORNER_W-1:0]   top,
    input  logic [dbd_pkg::CORNER_W-1:0]   right,
    input  logic [dbd_pkg::CORNER_W-1:0]   bottom,
    input  logic [dbd_pkg::SCORE_W-1:0]    score,
    output int unsigned                    error_count,
    output int unsigned                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import dbd_pkg::*;

    localparam int COORD_FRAC = 4;
    localparam int SCALE_FRAC = 16;

    typedef struct packed {
        logic                keep;
        logic [CORNER_W-1:0] x_left;
        logic [CORNER_W-1:0] y_top;
        logic [CORNER_W-1:0] x_right;
        logic [CORNER_W-1:0] y_bottom;
        logic [SCORE_W-1:0]  score;
    } box_result_t;

    // Our own copy of the register file.
    logic [15:0] min_score;
    logic [12:0] lb_side;
    logic [11:0] pad_x;
    logic [11:0] pad_y;
    logic [23:0] back_scale;
    logic [12:0] img_w;
    logic [12:0] img_h;
    logic [1:0]  score_mode;

    box_result_t expected_boxes[$];

    initial error_count = 0;

    // Divide by 2^s and round to nearest, ties away from zero.
    function automatic longint round_half_away(longint v, int s);
        longint half;
        half = longint'(1) << (s - 1);
        if (v >= 0)
            return (v + half) >>> s;
        return -((-v + half) >>> s);
    endfunction

    // Highest corner value allowed for an image side, saturated to the field width.
    function automatic longint corner_limit(logic [12:0] side);
        longint lim;
        lim = longint'(side) - 1;
        if (lim < 0)
            lim = 0;
        if (lim > longint'(CORNER_MAX))
            lim = longint'(CORNER_MAX);
        return lim;
    endfunction

    function automatic longint clamp_to(longint v, longint hi);
        if (v < 0)
            return 0;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Expected result of one row under the current register values.
    function automatic box_result_t predict_box(logic [15:0] cx, logic [15:0] cy,
                                                logic [15:0] bw, logic [15:0] bh,
                                                logic [15:0] sa, logic [15:0] sb);
        box_result_t res;
        logic [31:0] prod;
        logic [15:0] row_score;
        longint      x0, y0, wd, ht, x1, y1, x2, y2, lbs, sc;
        longint      l, t, r, b, lim_w, lim_h;
        res = '0;

        // Score selection and threshold.
        case (score_mode)
            FMT_DIRECT:    row_score = sa;
            FMT_OBJ_CLASS:
            begin
                prod = {16'd0, sa} * {16'd0, sb};
                row_score = prod[31:16];
            end
            default:       return res;
        endcase
        if (row_score < min_score)
            return res;

        // Integer box in letterbox pixels, clipped to the letterbox square.
        x0  = round_half_away(2 * longint'(cx) - longint'(bw), COORD_FRAC + 1);
        y0  = round_half_away(2 * longint'(cy) - longint'(bh), COORD_FRAC + 1);
        wd  = round_half_away(longint'(bw), COORD_FRAC);
        ht  = round_half_away(longint'(bh), COORD_FRAC);
        lbs = longint'(lb_side);
        x1  = (x0 > 0) ? x0 : 0;
        y1  = (y0 > 0) ? y0 : 0;
        x2  = (x0 + wd < lbs) ? x0 + wd : lbs;
        y2  = (y0 + ht < lbs) ? y0 + ht : lbs;
        if (x2 - x1 <= 0 || y2 - y1 <= 0)
            return res;

        // Strip the padding, scale back to the source image and clamp.
        sc    = longint'(back_scale);
        lim_w = corner_limit(img_w);
        lim_h = corner_limit(img_h);
        l = clamp_to(round_half_away((x1 - longint'(pad_x)) * sc, SCALE_FRAC), lim_w);
        r = clamp_to(round_half_away((x2 - longint'(pad_x)) * sc, SCALE_FRAC), lim_w);
        t = clamp_to(round_half_away((y1 - longint'(pad_y)) * sc, SCALE_FRAC), lim_h);
        b = clamp_to(round_half_away((y2 - longint'(pad_y)) * sc, SCALE_FRAC), lim_h);
        if (r == l || b == t)
            return res;

        res.keep     = 1'b1;
        res.x_left   = l[11:0];
        res.y_top    = t[11:0];
        res.x_right  = r[11:0];
        res.y_bottom = b[11:0];
        res.score    = row_score;
        return res;
    endfunction

    task automatic note_mismatch(string what, box_result_t want, box_result_t got);
        error_count++;
        if (error_count <= 10)
            $display("%0t ns: box result %s: expected keep=%0d l=%0d t=%0d r=%0d b=%0d s=%0d,",
                     $time, what, want.keep, want.x_left, want.y_top, want.x_right,
                     want.y_bottom, want.score,
                     " got keep=%0d l=%0d t=%0d r=%0d b=%0d s=%0d",
                     got.keep, got.x_left, got.y_top, got.x_right, got.y_bottom,
                     got.score);
    endtask

    // Watch all three channels at every rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        box_result_t want;
        box_result_t got;
        if (!rst_n)
        begin
            min_score   = RST_CONF_THRESHOLD;
            lb_side     = RST_LETTERBOX_SIZE;
            pad_x       = RST_PAD_LEFT;
            pad_y       = RST_PAD_TOP;
            back_scale  = RST_INV_SCALE;
            img_w       = RST_ORIG_WIDTH;
            img_h       = RST_ORIG_HEIGHT;
            score_mode  = RST_SCORE_FORMAT;
            expected_boxes.delete();
            outstanding <= 0;
        end
        else
        begin
            // Compare a finished result with the oldest prediction.
            if (done)
            begin
                got.keep     = keep;
                got.x_left   = left;
                got.y_top    = top;
                got.x_right  = right;
                got.y_bottom = bottom;
                got.score    = score;
                if (expected_boxes.size() == 0)
                    note_mismatch("with no request pending", '0, got);
                else
                begin
                    want = expected_boxes.pop_front();
                    if (got.keep !== want.keep || got.x_left !== want.x_left ||
                        got.y_top !== want.y_top || got.x_right !== want.x_right ||
                        got.y_bottom !== want.y_bottom || got.score !== want.score)
                        note_mismatch("differs", want, got);
                end
            end

            // Predict each accepted request with the registers in force at that edge.
            if (start && !busy)
                expected_boxes.insert(expected_boxes.size(),
                                      predict_box(center_x, center_y, box_width,
                                                  box_height, score_a, score_b));

            // Register writes take effect for later requests.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    REG_CONF_THRESHOLD: min_score  = cfg_data[15:0];
                    REG_LETTERBOX_SIZE: lb_side    = cfg_data[12:0];
                    REG_PAD_LEFT:       pad_x      = cfg_data[11:0];
                    REG_PAD_TOP:        pad_y      = cfg_data[11:0];
                    REG_INV_SCALE:      back_scale = cfg_data[23:0];
                    REG_ORIG_WIDTH:     img_w      = cfg_data[12:0];
                    REG_ORIG_HEIGHT:    img_h      = cfg_data[12:0];
                    REG_SCORE_FORMAT:   score_mode = cfg_data[1:0];
                    default:            ;
                endcase
            end
            outstanding <= expected_boxes.size();
        end
    end

endmodule

// ===== verif/tb_detection_box_decode_top.sv =====
// Testbench top for the detection box decoder: clock, reset, register writes and row requests.
// Instantiates detection_box_decode_top and detection_box_decode_checker; uses dbd_pkg.
module tb_detection_box_decode_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dbd_pkg::*;

    // Score format codes that the block treats as drop-all.
    localparam logic [1:0] FMT_DROP_ALL    = 2'd2;
    localparam logic [1:0] FMT_DROP_ALL_HI = 2'd3;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  start      = 1'b0;
    logic                  busy;
    logic [COORD_W-1:0]    center_x   = '0;
    logic [COORD_W-1:0]    center_y   = '0;
    logic [COORD_W-1:0]    box_width  = '0;
    logic [COORD_W-1:0]    box_height = '0;
    logic [SCORE_W-1:0]    score_a    = '0;
    logic [SCORE_W-1:0]    score_b    = '0;
    logic                  done;
    logic                  keep;
    logic [CORNER_W-1:0]   left;
    logic [CORNER_W-1:0]   top;
    logic [CORNER_W-1:0]   right;
    logic [CORNER_W-1:0]   bottom;
    logic [SCORE_W-1:0]    score;
    int unsigned           error_count;
    int unsigned           outstanding;

    // Values the row generator needs to aim boxes and scores.
    int thr_cur = int'(RST_CONF_THRESHOLD);
    int lb_cur  = int'(RST_LETTERBOX_SIZE);
    bit steady  = 1'b0;

    detection_box_decode_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .start      (start),
        .busy       (busy),
        .center_x   (center_x),
        .center_y   (center_y),
        .box_width  (box_width),
        .box_height (box_height),
        .score_a    (score_a),
        .score_b    (score_b),
        .done       (done),
        .keep       (keep),
        .left       (left),
        .top        (top),
        .right      (right),
        .bottom     (bottom),
        .score      (score)
    );

    detection_box_decode_checker u_boxcheck (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .start       (start),
        .busy        (busy),
        .center_x    (center_x),
        .center_y    (center_y),
        .box_width   (box_width),
        .box_height  (box_height),
        .score_a     (score_a),
        .score_b     (score_b),
        .done        (done),
        .keep        (keep),
        .left        (left),
        .top         (top),
        .right       (right),
        .bottom      (bottom),
        .score       (score),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    always #4 clk = ~clk;

    // Random idle cycles ahead of a request or a register write, none during a steady stretch.
    function automatic int pick_gap();
        int g;
        g = 0;
        if (!steady)
            while ($urandom_range(99) < 28)
                g++;
        return g;
    endfunction

    // Write one register; valid stays up so that writes can run back to back.
    task automatic write_reg(input cfg_idx_t idx, input logic [23:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cfg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Load the whole register file.
    task automatic apply_config(input logic [15:0] thr, input logic [12:0] lb,
                                input logic [11:0] pl, input logic [11:0] pt,
                                input logic [23:0] inv, input logic [12:0] ow,
                                input logic [12:0] oh, input logic [1:0] fmt);
        write_reg(REG_CONF_THRESHOLD, 24'(thr));
        write_reg(REG_LETTERBOX_SIZE, 24'(lb));
        write_reg(REG_PAD_LEFT, 24'(pl));
        write_reg(REG_PAD_TOP, 24'(pt));
        write_reg(REG_INV_SCALE, inv);
        write_reg(REG_ORIG_WIDTH, 24'(ow));
        write_reg(REG_ORIG_HEIGHT, 24'(oh));
        write_reg(REG_SCORE_FORMAT, 24'(fmt));
        cfg_valid <= 1'b0;
        thr_cur = int'(thr);
        lb_cur  = int'(lb);
    endtask

    // Present one row request and hold it until accepted.
    task automatic send_row(input logic [15:0] cx, input logic [15:0] cy,
                            input logic [15:0] bw, input logic [15:0] bh,
                            input logic [15:0] sa, input logic [15:0] sb);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        center_x   <= cx;
        center_y   <= cy;
        box_width  <= bw;
        box_height <= bh;
        score_a    <= sa;
        score_b    <= sb;
        do @(posedge clk); while (busy);
    endtask

    // Stop requesting and wait until every predicted result has come back.
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Stimulus and verdict.
    initial
    begin
        int          span;
        logic [15:0] cx, cy, bw, bh, sa, sb;
        logic [15:0] thr;
        logic [12:0] lb, ow, oh;
        logic [11:0] pl, pt;
        logic [23:0] inv;
        logic [1:0]  fmt;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset register values: threshold edges, clipping, rounding ties, empty boxes.
        send_row(16'd2560, 16'd1920, 16'd640, 16'd480, 16'd16384, 16'd0);
        send_row(16'd2560, 16'd1920, 16'd640, 16'd480, 16'd16383, 16'hFFFF);
        send_row(16'd0, 16'd0, 16'd1024, 16'd1024, 16'hFFFF, 16'hFFFF);
        send_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_row(16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0);
        send_row(16'd6400, 16'd1600, 16'd320, 16'd320, 16'hFFFF, 16'd0);
        send_row(16'd24, 16'd24, 16'd32, 16'd32, 16'd40000, 16'd0);
        send_row(16'd8, 16'd8, 16'd32, 16'd32, 16'd40000, 16'd0);
        send_row(16'd1600, 16'd1600, 16'd8, 16'd8, 16'd40000, 16'd0);
        send_row(16'd5040, 16'd5040, 16'd160, 16'd160, 16'd40000, 16'd0);
        drain();

        // Product score, widest letterbox, largest scale, oversized image.
        apply_config(16'd0, 13'd8191, 12'd0, 12'd0, 24'hFFFFFF, 13'd8191, 13'd8191,
                     FMT_OBJ_CLASS);
        send_row(16'd80, 16'd80, 16'd160, 16'd160, 16'd0, 16'd0);
        send_row(16'd80, 16'd80, 16'd160, 16'd160, 16'hFFFF, 16'hFFFF);
        send_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1);
        drain();

        // Unsupported score formats drop everything.
        apply_config(RST_CONF_THRESHOLD, RST_LETTERBOX_SIZE, RST_PAD_LEFT, RST_PAD_TOP,
                     RST_INV_SCALE, RST_ORIG_WIDTH, RST_ORIG_HEIGHT, FMT_DROP_ALL);
        send_row(16'd2560, 16'd1920, 16'd640, 16'd480, 16'hFFFF, 16'hFFFF);
        drain();
        apply_config(RST_CONF_THRESHOLD, RST_LETTERBOX_SIZE, RST_PAD_LEFT, RST_PAD_TOP,
                     RST_INV_SCALE, RST_ORIG_WIDTH, RST_ORIG_HEIGHT, FMT_DROP_ALL_HI);
        send_row(16'd2560, 16'd1920, 16'd640, 16'd480, 16'hFFFF, 16'hFFFF);
        drain();

        // Zero letterbox leaves no area.
        apply_config(16'd0, 13'd0, RST_PAD_LEFT, RST_PAD_TOP, RST_INV_SCALE,
                     RST_ORIG_WIDTH, RST_ORIG_HEIGHT, FMT_DIRECT);
        send_row(16'd2560, 16'd1920, 16'd640, 16'd480, 16'hFFFF, 16'd0);
        drain();

        // Zero image width, then zero image height.
        apply_config(16'd0, RST_LETTERBOX_SIZE, RST_PAD_LEFT, RST_PAD_TOP, RST_INV_SCALE,
                     13'd0, RST_ORIG_HEIGHT, FMT_DIRECT);
        send_row(16'd2560, 16'd1920, 16'd640, 16'd480, 16'hFFFF, 16'd0);
        drain();
        apply_config(16'd0, RST_LETTERBOX_SIZE, RST_PAD_LEFT, RST_PAD_TOP, RST_INV_SCALE,
                     RST_ORIG_WIDTH, 13'd0, FMT_DIRECT);
        send_row(16'd2560, 16'd1920, 16'd640, 16'd480, 16'hFFFF, 16'd0);
        drain();

        // Zero scale maps every corner to the origin.
        apply_config(16'd0, RST_LETTERBOX_SIZE, RST_PAD_LEFT, RST_PAD_TOP, 24'd0,
                     RST_ORIG_WIDTH, RST_ORIG_HEIGHT, FMT_DIRECT);
        send_row(16'd2560, 16'd1920, 16'd640, 16'd480, 16'hFFFF, 16'd0);
        drain();

        // Padding pushes corners negative: a rounding tie below zero, then full padding.
        apply_config(16'd0, RST_LETTERBOX_SIZE, 12'd1, 12'd1, 24'd32768,
                     RST_ORIG_WIDTH, RST_ORIG_HEIGHT, FMT_DIRECT);
        send_row(16'd80, 16'd80, 16'd160, 16'd160, 16'hFFFF, 16'd0);
        drain();
        apply_config(16'd0, RST_LETTERBOX_SIZE, 12'hFFF, 12'hFFF, RST_INV_SCALE,
                     RST_ORIG_WIDTH, RST_ORIG_HEIGHT, FMT_DIRECT);
        send_row(16'd2560, 16'd1920, 16'd640, 16'd480, 16'hFFFF, 16'd0);
        drain();

        // Random phases, each with its own register setting.
        for (int ph = 0; ph < 8; ph++)
        begin
            case ($urandom_range(3))
                0:       thr = 16'd0;
                1:       thr = 16'($urandom);
                default: thr = 16'($urandom_range(0, 40000));
            endcase
            lb  = ($urandom_range(99) < 85) ? 13'($urandom_range(16, 640)) : 13'($urandom);
            pl  = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(0, lb / 4));
            pt  = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(0, lb / 4));
            inv = ($urandom_range(4) == 0) ? 24'($urandom)
                                           : 24'($urandom_range(16384, 262144));
            ow  = ($urandom_range(5) == 0) ? 13'($urandom) : 13'($urandom_range(1, 4096));
            oh  = ($urandom_range(5) == 0) ? 13'($urandom) : 13'($urandom_range(1, 4096));
            case ($urandom_range(9))
                0:          fmt = FMT_DROP_ALL;
                1:          fmt = FMT_DROP_ALL_HI;
                2, 3, 4, 5: fmt = FMT_DIRECT;
                default:    fmt = FMT_OBJ_CLASS;
            endcase
            steady = (ph == 3);
            apply_config(thr, lb, pl, pt, inv, ow, oh, fmt);

            repeat (106)
            begin
                // Mostly boxes aimed at the letterbox with passing scores, some raw noise.
                span = (lb_cur * 16 > 65535) ? 65535 : lb_cur * 16;
                if ($urandom_range(99) < 70)
                begin
                    cx = 16'($urandom_range(0, span));
                    cy = 16'($urandom_range(0, span));
                    bw = 16'($urandom_range(0, span / 2 + 32));
                    bh = 16'($urandom_range(0, span / 2 + 32));
                    sa = 16'($urandom_range(thr_cur, 65535));
                    sb = $urandom_range(1) ? 16'($urandom_range(thr_cur, 65535))
                                           : 16'(16'hFFFF - $urandom_range(0, 255));
                end
                else
                begin
                    cx = 16'($urandom);
                    cy = 16'($urandom);
                    bw = 16'($urandom);
                    bh = 16'($urandom);
                    sa = 16'($urandom);
                    sb = 16'($urandom);
                end
                send_row(cx, cy, bw, bh, sa, sb);
            end
            drain();
        end

        repeat (10) @(posedge clk);
        if (error_count == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #1ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
